>>> rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, held off while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> rtl/core/scfl_pkg.sv
// Types and constants for the size-class free-list allocator.
// No dependencies; used by every module in rtl/core.
package scfl_pkg;

	localparam int POOL_BYTES      = 262144;
	localparam int NUM_CLASSES     = 8;
	localparam int MAX_CLASS_BYTES = 2048;

	localparam int GRANULE_SHIFT = 4;
	localparam int GRANULE_BYTES = 16;
	localparam int GRANULES      = POOL_BYTES / GRANULE_BYTES;
	localparam int GRAN_W        = $clog2(GRANULES);
	localparam int CLS_W         = $clog2(NUM_CLASSES);
	localparam int BUMP_W        = $clog2(POOL_BYTES) + 1;
	localparam int SIZE_W        = 12;
	localparam int ADDR_W        = 18;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_TOO_LARGE = 2'd1,
		STS_EXHAUSTED = 2'd2
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [SIZE_W-1:0]  request_size;
		logic [ADDR_W-1:0]  block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted_address;
		status_t           status;
	} rsp_t;

	// One free-list link: next granule plus a flag that it is not the list end.
	typedef struct packed {
		logic              valid;
		logic [GRAN_W-1:0] granule;
	} link_slot_t;

	// One access to the link memory.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [GRAN_W-1:0] addr;
		link_slot_t        wdata;
	} link_req_t;

endpackage

>>> rtl/core/scfl_size_class.sv
// Size to power-of-two class decoder.
// Depends on scfl_pkg.
module scfl_size_class (
	input  logic [scfl_pkg::SIZE_W-1:0] request_size,
	output logic [scfl_pkg::CLS_W-1:0]  cls,
	output logic                        too_large
);

	logic [scfl_pkg::SIZE_W:0]   size_rnd;
	logic [scfl_pkg::SIZE_W-4:0] units;
	logic [scfl_pkg::SIZE_W-4:0] units_m1;
	logic [3:0]                  bit_len;

	// units = ceil(size / 16); class = bit length of (units - 1)
	assign size_rnd = {1'b0, request_size} + (scfl_pkg::SIZE_W+1)'(scfl_pkg::GRANULE_BYTES - 1);
	assign units    = size_rnd[scfl_pkg::SIZE_W:scfl_pkg::GRANULE_SHIFT];
	assign units_m1 = (units == '0) ? '0 : units - 1'b1;

	always_comb begin
		bit_len = '0;
		for (int i = 0; i < scfl_pkg::SIZE_W - 3; i++) begin
			if (units_m1[i]) begin
				bit_len = 4'(i + 1);
			end
		end
	end

	assign cls       = bit_len[scfl_pkg::CLS_W-1:0];
	assign too_large = (request_size > scfl_pkg::SIZE_W'(scfl_pkg::MAX_CLASS_BYTES)) ||
		(bit_len >= 4'(scfl_pkg::NUM_CLASSES));

endmodule

>>> rtl/core/scfl_link_mem.sv
// Link memory: next pointer per 16-byte granule, one port, registered read.
// Depends on scfl_pkg.
module scfl_link_mem (
	input  logic                   clk,
	input  scfl_pkg::link_req_t    link_req,
	output scfl_pkg::link_slot_t   rdata_q
);

	scfl_pkg::link_slot_t mem [scfl_pkg::GRANULES];

	always_ff @(posedge clk) begin
		if (link_req.we) begin
			mem[link_req.addr] <= link_req.wdata;
		end
		if (link_req.re) begin
			rdata_q <= mem[link_req.addr];
		end
	end

endmodule

>>> rtl/core/size_class_free_list_allocator.sv
// Size-class free-list allocator, top level.
// Depends on scfl_pkg, scfl_size_class, scfl_link_mem and assert_macros.svh.
//
// One request per item: allocate request_size bytes, or free the block at
// block_address of that size. Sizes up to 2048 bytes round up to eight
// power-of-two classes (16 to 2048 bytes); larger sizes return status
// too-large and change nothing. Each class keeps a LIFO free list whose head
// sits in flip-flops and whose next links sit in a 16K-entry link memory,
// one entry per 16-byte granule of the 256 KiB pool. An allocation pops its
// list, or bump-allocates from the pool when the list is empty; status
// exhausted is returned when the pool cannot cover the class size. A free
// pushes the granule onto its list with no double-free check; the low four
// address bits are ignored. Every request yields exactly one response.
// Timing: an allocation served from a free list takes two cycles, since the
// new head must be read from the link memory (one-cycle read latency); all
// other requests take one cycle. A request may be taken in the same cycle
// as the previous response leaves; while a response is held by rsp_stall no
// new request is taken. No clearing pass follows reset: a link entry is
// read only after a free has written it.
`include "assert_macros.svh"

module size_class_free_list_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  scfl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output scfl_pkg::rsp_t  rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_POP  = 2'b10
	} fsm_t;

	fsm_t                               state_q;
	logic [scfl_pkg::NUM_CLASSES-1:0]   head_vld_q;
	logic [scfl_pkg::GRAN_W-1:0]        head_gran_q [scfl_pkg::NUM_CLASSES];
	logic [scfl_pkg::BUMP_W-1:0]        bump_q;
	logic [scfl_pkg::CLS_W-1:0]         pop_cls_q;
	logic [scfl_pkg::GRAN_W-1:0]        pop_gran_q;
	logic                               rsp_valid_q;
	scfl_pkg::rsp_t                     rsp_q;

	logic [scfl_pkg::CLS_W-1:0]         cls;
	logic                               too_large;
	logic                               accept;
	logic                               head_hit;
	logic [scfl_pkg::BUMP_W-1:0]        class_bytes;
	logic [scfl_pkg::BUMP_W-1:0]        remaining;
	logic                               exhausted;
	logic [scfl_pkg::GRAN_W-1:0]        free_gran;
	scfl_pkg::link_req_t                link_req;
	scfl_pkg::link_slot_t               link_rdata;

	scfl_size_class u_size_class (
		.request_size (req.request_size),
		.cls          (cls),
		.too_large    (too_large)
	);

	scfl_link_mem u_link_mem (
		.clk      (clk),
		.link_req (link_req),
		.rdata_q  (link_rdata)
	);

	// Stall while a pop is in flight or the response register cannot drain.
	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	assign head_hit    = head_vld_q[cls];
	assign class_bytes = scfl_pkg::BUMP_W'(scfl_pkg::GRANULE_BYTES) << cls;
	assign remaining   = scfl_pkg::BUMP_W'(scfl_pkg::POOL_BYTES) - bump_q;
	assign exhausted   = remaining < class_bytes;
	assign free_gran   = req.block_address[scfl_pkg::GRANULE_SHIFT +: scfl_pkg::GRAN_W];

	// Link memory: free writes the old head behind the new one; a list pop
	// reads the link of the granule being handed out.
	always_comb begin
		link_req       = '0;
		link_req.addr  = head_gran_q[cls];
		link_req.wdata = '{valid: head_vld_q[cls], granule: head_gran_q[cls]};
		if (accept && !too_large) begin
			if (req.operation == scfl_pkg::OP_FREE) begin
				link_req.we   = 1'b1;
				link_req.addr = free_gran;
			end else if (head_hit) begin
				link_req.re = 1'b1;
			end
		end
	end

	// Control, list heads and bump pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_vld_q  <= '0;
			bump_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (too_large) begin
							rsp_valid_q <= 1'b1;
						end else if (req.operation == scfl_pkg::OP_FREE) begin
							head_vld_q[cls] <= 1'b1;
							rsp_valid_q     <= 1'b1;
						end else if (head_hit) begin
							state_q <= S_POP;
						end else begin
							if (!exhausted) begin
								bump_q <= bump_q + class_bytes;
							end
							rsp_valid_q <= 1'b1;
						end
					end
				end
				S_POP: begin
					head_vld_q[pop_cls_q] <= link_rdata.valid;
					rsp_valid_q           <= 1'b1;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: head granules, pop context and the response
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			pop_cls_q  <= cls;
			pop_gran_q <= head_gran_q[cls];
			if (too_large) begin
				rsp_q <= '{granted_address: '0, status: scfl_pkg::STS_TOO_LARGE};
			end else if (req.operation == scfl_pkg::OP_FREE) begin
				head_gran_q[cls] <= free_gran;
				rsp_q <= '{granted_address: '0, status: scfl_pkg::STS_OK};
			end else if (!head_hit) begin
				if (exhausted) begin
					rsp_q <= '{granted_address: '0, status: scfl_pkg::STS_EXHAUSTED};
				end else begin
					rsp_q <= '{granted_address: bump_q[scfl_pkg::ADDR_W-1:0],
						status: scfl_pkg::STS_OK};
				end
			end
		end else if (state_q == S_POP) begin
			head_gran_q[pop_cls_q] <= link_rdata.granule;
			rsp_q <= '{granted_address: {pop_gran_q, {scfl_pkg::GRANULE_SHIFT{1'b0}}},
				status: scfl_pkg::STS_OK};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A pop must never find the response register still occupied.
	`ASSERT_NEVER(a_pop_rsp_free, clk, arst_n, (state_q == S_POP) && rsp_valid_q)
	// No request may be taken while a pop is in flight.
	`ASSERT_NEVER(a_pop_no_accept, clk, arst_n, (state_q == S_POP) && accept)
	// The bump pointer never passes the end of the pool.
	`ASSERT_CLK(a_bump_in_pool, clk, arst_n,
		bump_q <= scfl_pkg::BUMP_W'(scfl_pkg::POOL_BYTES))
	// A list hit on alloc goes to the pop step and then returns a response.
	`ASSERT_CLK(a_hit_pops, clk, arst_n,
		(accept && !too_large && req.operation == scfl_pkg::OP_ALLOC && head_hit)
		|=> (state_q == S_POP) ##1 rsp_valid_q)

endmodule
